/* sv/fafs_pkg.sv */
package fafs_pkg;

    // default frame pool size
    localparam int FAFS_NUM_FRAMES = 64;

    // fixed field widths
    localparam int ID_W    = 16;
    localparam int COUNT_W = 7;
    localparam int STAMP_W = 32;
    localparam int FRAME_W = 6;

    // packed stream widths
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 48;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_req_cmd;

    typedef enum logic [1:0] {
        ST_GRANTED = 2'd0,
        ST_REFUSED = 2'd1,
        ST_FREED   = 2'd2,
        ST_EMPTY   = 2'd3
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic scan;
        logic flush;
        logic refuse;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic refuse_req;
        logic is_free;
        logic scan_end;
        logic alloc_done;
        logic slot_free;
    } t_dp_stat;

endpackage

/* sv/fafs_ctrl.sv */
module fafs_ctrl
    import fafs_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_tvalid,
    input  t_req_cmd i_req_cmd,
    input  t_dp_stat i_stat,
    output logic     o_s_tready,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_FLUSH  = 4'b0100,
        S_REFUSE = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_req_cmd == CMD_ALLOC && i_stat.refuse_req) begin
                        n_state = S_REFUSE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (i_stat.alloc_done) begin
                    n_state = S_IDLE;
                end else if (i_stat.scan_end) begin
                    n_state = i_stat.is_free ? S_FLUSH : S_IDLE;
                end
            end
            S_FLUSH, S_REFUSE: begin
                if (i_stat.slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd.accept = accept;
    assign o_cmd.scan   = (r_state == S_SCAN);
    assign o_cmd.flush  = (r_state == S_FLUSH);
    assign o_cmd.refuse = (r_state == S_REFUSE);

endmodule

/* sv/fafs_dp.sv */
module fafs_dp
    import fafs_pkg::*;
#(
    parameter int NUM_FRAMES = FAFS_NUM_FRAMES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_stat           o_stat,
    input  t_req_cmd           i_req_cmd,
    input  logic [ID_W-1:0]    i_proc_id,
    input  logic [COUNT_W-1:0] i_request_count,
    input  logic [STAMP_W-1:0] i_event_time,
    input  logic               i_m_tready,
    output logic               o_out_valid,
    output t_status            o_status,
    output logic [FRAME_W-1:0] o_frame_index,
    output logic [STAMP_W-1:0] o_evict_stamp,
    output logic [COUNT_W-1:0] o_free_frames,
    output logic               o_last
);

    localparam int AW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;

    // request registers
    t_req_cmd           r_cmd;
    logic [ID_W-1:0]    r_id;
    logic [COUNT_W-1:0] r_want;
    logic [STAMP_W-1:0] r_stamp;

    // pool state
    logic [NUM_FRAMES-1:0] r_used;
    logic [ID_W-1:0]       r_owner_mem [NUM_FRAMES];
    logic [COUNT_W-1:0]    r_free_cnt;

    // scan pipeline: read issue, then compare
    logic [COUNT_W-1:0] r_idx;
    logic               r_rd_valid;
    logic [AW-1:0]      r_rd_idx;
    logic [ID_W-1:0]    r_rd_owner;
    logic [COUNT_W-1:0] r_got;

    // freed frame held back until it is known whether it is the last
    logic               r_pend_valid;
    logic [AW-1:0]      r_pend_idx;
    logic [COUNT_W-1:0] r_pend_cnt;

    // output register
    logic               r_out_valid;
    t_status            r_out_status;
    logic [FRAME_W-1:0] r_out_frame;
    logic [STAMP_W-1:0] r_out_stamp;
    logic [COUNT_W-1:0] r_out_cnt;
    logic               r_out_last;

    logic               slot_free;
    logic               is_alloc;
    logic               cur_used;
    logic               hit;
    logic               stage_live;
    logic               need_out;
    logic               adv;
    logic               fire;
    logic               issue;
    logic               got_last;
    logic               out_load;
    t_status            n_out_status;
    logic [FRAME_W-1:0] n_out_frame;
    logic [STAMP_W-1:0] n_out_stamp;
    logic [COUNT_W-1:0] n_out_cnt;
    logic               n_out_last;

    always_comb begin
        slot_free  = !r_out_valid || i_m_tready;
        is_alloc   = (r_cmd == CMD_ALLOC);
        cur_used   = r_used[r_rd_idx];
        hit        = is_alloc ? !cur_used : (cur_used && r_rd_owner == r_id);
        stage_live = i_cmd.scan && r_rd_valid;
        need_out   = stage_live && hit && (is_alloc || r_pend_valid);
        adv        = i_cmd.scan && (!need_out || slot_free);
        fire       = stage_live && adv;
        issue      = adv && (r_idx < COUNT_W'(NUM_FRAMES));
        got_last   = ((r_got + 1'b1) == r_want);
    end

    always_comb begin
        out_load     = 1'b0;
        n_out_status = ST_EMPTY;
        n_out_frame  = '0;
        n_out_stamp  = '0;
        n_out_cnt    = r_free_cnt;
        n_out_last   = 1'b1;
        if (need_out && slot_free) begin
            out_load = 1'b1;
            if (is_alloc) begin
                n_out_status = ST_GRANTED;
                n_out_frame  = FRAME_W'(r_rd_idx);
                n_out_cnt    = r_free_cnt - 1'b1;
                n_out_last   = got_last;
            end else begin
                n_out_status = ST_FREED;
                n_out_frame  = FRAME_W'(r_pend_idx);
                n_out_stamp  = r_stamp;
                n_out_cnt    = r_pend_cnt;
                n_out_last   = 1'b0;
            end
        end else if (i_cmd.flush && slot_free) begin
            out_load = 1'b1;
            if (r_pend_valid) begin
                n_out_status = ST_FREED;
                n_out_frame  = FRAME_W'(r_pend_idx);
                n_out_stamp  = r_stamp;
                n_out_cnt    = r_pend_cnt;
            end
        end else if (i_cmd.refuse && slot_free) begin
            out_load     = 1'b1;
            n_out_status = ST_REFUSED;
        end
    end

    // request capture, pool state and scan control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used       <= '0;
            r_free_cnt   <= COUNT_W'(NUM_FRAMES);
            r_rd_valid   <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_cmd        <= i_req_cmd;
                r_id         <= i_proc_id;
                r_want       <= i_request_count;
                r_stamp      <= i_event_time;
                r_idx        <= '0;
                r_rd_valid   <= 1'b0;
                r_got        <= '0;
                r_pend_valid <= 1'b0;
            end else if (adv) begin
                if (issue) begin
                    r_rd_idx   <= r_idx[AW-1:0];
                    r_rd_valid <= 1'b1;
                    r_idx      <= r_idx + 1'b1;
                end else begin
                    r_rd_valid <= 1'b0;
                end
            end
            if (fire && hit) begin
                if (is_alloc) begin
                    r_used[r_rd_idx] <= 1'b1;
                    r_free_cnt       <= r_free_cnt - 1'b1;
                    r_got            <= r_got + 1'b1;
                end else begin
                    r_used[r_rd_idx] <= 1'b0;
                    r_free_cnt       <= r_free_cnt + 1'b1;
                    r_pend_valid     <= 1'b1;
                    r_pend_idx       <= r_rd_idx;
                    r_pend_cnt       <= r_free_cnt + 1'b1;
                end
            end
        end
    end

    // owner store, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (fire && hit && is_alloc) begin
            r_owner_mem[r_rd_idx] <= r_id;
        end
        if (issue) begin
            r_rd_owner <= r_owner_mem[r_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_status <= n_out_status;
            r_out_frame  <= n_out_frame;
            r_out_stamp  <= n_out_stamp;
            r_out_cnt    <= n_out_cnt;
            r_out_last   <= n_out_last;
        end
    end

    assign o_stat.refuse_req = (i_request_count == '0) || (i_request_count > r_free_cnt);
    assign o_stat.is_free    = !is_alloc;
    assign o_stat.scan_end   = fire && (r_rd_idx == AW'(NUM_FRAMES - 1));
    assign o_stat.alloc_done = fire && hit && is_alloc && got_last;
    assign o_stat.slot_free  = slot_free;

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_frame_index = r_out_frame;
    assign o_evict_stamp = r_out_stamp;
    assign o_free_frames = r_out_cnt;
    assign o_last        = r_out_last;

endmodule

/* sv/frame_allocator_first_free.sv */
// First-fit page frame allocator. The block keeps an owner id and a used bit for each
// frame of a pool of NUM_FRAMES frames plus a count of free frames. An allocate request
// (tuser 0) claims the lowest-numbered free frames in ascending order and gives one
// granted transfer per frame, or a single refused transfer when the count is zero or
// above the free count. A free request (tuser 1) releases every frame of the process
// and gives one freed transfer per frame carrying the request's time stamp, or a single
// "nothing owned" transfer. tlast marks the final transfer of each request. A request
// walks the frame table one entry per cycle through the registered-read owner store, except
// while a result waits in a stalled output register; a new request is taken once the final
// result sits in the output register.
module frame_allocator_first_free
    import fafs_pkg::*;
#(
    parameter int NUM_FRAMES = FAFS_NUM_FRAMES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request stream
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,  // proc_id[15:0], request_count[22:16],
                                             // event_time[54:23], zero fill
    input  logic                 i_s_tuser,  // cmd: 0 allocate, 1 free
    // result stream
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata,  // frame_index[5:0], evict_stamp[37:6],
                                             // free_frames[44:38], zero fill
    output logic [1:0]           o_m_tuser,  // status
    output logic                 o_m_tlast   // final transfer of a request
);

    t_dp_cmd            cmd;
    t_dp_stat           stat;
    t_req_cmd           req_cmd;
    t_status            status;
    logic [FRAME_W-1:0] frame_index;
    logic [STAMP_W-1:0] evict_stamp;
    logic [COUNT_W-1:0] free_frames;

    assign req_cmd = t_req_cmd'(i_s_tuser);

    fafs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_req_cmd  (req_cmd),
        .i_stat     (stat),
        .o_s_tready (o_s_tready),
        .o_cmd      (cmd)
    );

    fafs_dp #(
        .NUM_FRAMES (NUM_FRAMES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_req_cmd       (req_cmd),
        .i_proc_id       (i_s_tdata[15:0]),
        .i_request_count (i_s_tdata[22:16]),
        .i_event_time    (i_s_tdata[54:23]),
        .i_m_tready      (i_m_tready),
        .o_out_valid     (o_m_tvalid),
        .o_status        (status),
        .o_frame_index   (frame_index),
        .o_evict_stamp   (evict_stamp),
        .o_free_frames   (free_frames),
        .o_last          (o_m_tlast)
    );

    // unused high byte bits of both tdata buses are zero fill
    assign o_m_tdata = {3'b000, free_frames, evict_stamp, frame_index};
    assign o_m_tuser = status;

endmodule

/* sv/fafs_checker.sv */
module fafs_checker
    import fafs_pkg::*;
#(
    parameter int NUM_FRAMES = FAFS_NUM_FRAMES
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_s_tvalid,
    input logic                 o_s_tready,
    input logic [S_TDATA_W-1:0] i_s_tdata,
    input logic                 i_s_tuser,
    input logic                 o_m_tvalid,
    input logic                 i_m_tready,
    input logic [M_TDATA_W-1:0] o_m_tdata,
    input logic [1:0]           o_m_tuser,
    input logic                 o_m_tlast
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("result changed while stalled");

    // free count never exceeds the pool
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[44:38] <= 7'(NUM_FRAMES))
        else $error("free count above pool size");

    // refused and empty results stand alone with no frame
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == ST_REFUSED || o_m_tuser == ST_EMPTY)
            |-> o_m_tlast && o_m_tdata[5:0] == '0 && o_m_tdata[37:6] == '0)
        else $error("refused or empty result malformed");

    // no new request while a request is still producing results
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast |-> !o_s_tready)
        else $error("request taken mid-request");

endmodule

bind frame_allocator_first_free fafs_checker #(.NUM_FRAMES(NUM_FRAMES)) u_fafs_checker (.*);
